// File: hw/rtl/lzo_pkg.sv
// Shared types and constants for the LZO1X stream decompressor.
package lzo_pkg;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_BAD_END  = 3'd1,
		ERR_DIST     = 3'd2,
		ERR_BUSY     = 3'd3,
		ERR_OVERFLOW = 3'd4
	} err_t;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic       we;
		logic [7:0] wdata;
		logic       re;
	} hist_ctl_t;

endpackage

// File: hw/rtl/lzo1x_stream_decompressor.sv
// LZO1X stream decompressor top level: parser, copy engine and result stage.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless in_stall is high; a history read is
// forwarded when it hits the byte being written in the same cycle.
// Reset (arst_n low) clears the parser and counters at once; the history
// memory is not cleared and needs no clearing pass.
module lzo1x_stream_decompressor #(
	parameter int HISTORY_DEPTH = 65536,
	parameter int LENGTH_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       res_valid,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       busy_res,
	output logic       done_res,
	output logic [2:0] error_code
);
	import lzo_pkg::*;

	localparam int AW = 16;
	localparam int CW = 17;
	localparam int LW = LENGTH_BITS;
	localparam logic [LW:0] LEN_MAX = {1'b0, {LW{1'b1}}};

	typedef enum logic [3:0] {
		PH_FIRST, PH_OPC_LIT, PH_OPC_AFTER_LIT, PH_OPC_AFTER_TRAIL, PH_LIT_EXT,
		PH_LITERALS, PH_TRAILS, PH_SHORT_A, PH_SHORT_B, PH_M34_EXT, PH_M34_D0,
		PH_M34_D1, PH_COPY, PH_DONE, PH_HALT
	} phase_t;

	phase_t        phase_q, ph_n;
	logic [AW-1:0] wpos_q, wpos_n, src_q, src_n;
	logic [CW-1:0] written_q, written_n;
	logic [LW-1:0] rem_q, rem_n;
	logic [7:0]    dist0_q, dist0_n, held_q, held_n;
	logic [1:0]    trail_q, trail_n;

	logic          fwd_s1, rd_s1;
	logic [7:0]    fwd_byte_q;
	logic          rvalid_s1;
	logic [7:0]    rbyte_s1;
	logic          rbusy_s1, rdone_s1;
	logic [2:0]    rerr_s1;
	logic          full_s1;
	logic          wr_q;
	logic [AW-1:0] waddr_q;

	hist_ctl_t     hctl;
	logic [7:0]    hrdata;
	logic          take;

	logic          v;
	logic          wr;
	logic [7:0]    ob;
	logic [2:0]    err;
	logic          is_copy;

	// The output stage holds at most one result; an item is taken when it is
	// free or being emptied in this cycle.
	assign in_stall = full_s1 && out_stall;
	assign take = in_valid && !in_stall;
	assign is_copy = take && action == ACT_TICK && phase_q == PH_COPY;

	// Each produced byte enters the history in the cycle after its transfer,
	// taken from the result stage, so a copy byte comes from the memory read.
	assign hctl = '{we: wr_q, wdata: out_byte, re: is_copy};

	lzo_history #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_hist (
		.clk(clk), .ctl(hctl), .waddr(waddr_q), .raddr(src_q), .rdata(hrdata)
	);

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		logic [AW:0] s;
		s = {1'b0, p} + 1'b1;
		return (s >= (AW+1)'(HISTORY_DEPTH)) ? '0 : s[AW-1:0];
	endfunction

	always_comb begin
		logic [CW-1:0] d;
		logic [LW:0]   len;
		logic [LW:0]   add;
		logic          do_match;
		logic [CW:0]   srcw;
		logic [15:0]   off;
		ph_n = phase_q; wpos_n = wpos_q; src_n = src_q; written_n = written_q;
		rem_n = rem_q; dist0_n = dist0_q; held_n = held_q; trail_n = trail_q;
		v = 1'b0; ob = 8'd0; err = ERR_OK; wr = 1'b0;
		d = '0; len = '0; add = '0; do_match = 1'b0; srcw = '0; off = '0;
		if (take) begin
			if (phase_q == PH_HALT) begin
				err = held_q[2:0];
			end else if (action == ACT_TICK) begin
				if (phase_q == PH_COPY) begin
					v = 1'b1;
					wr = 1'b1;
					src_n = nxt(src_q);
					if (rem_q != '0) rem_n = rem_q - 1'b1;
					if (rem_n == '0) ph_n = (trail_q != 2'd0) ? PH_TRAILS : PH_OPC_LIT;
				end
			end else if (phase_q == PH_DONE) begin
				err = ERR_BAD_END;
			end else if (phase_q == PH_COPY) begin
				err = ERR_BUSY;
			end else begin
				case (phase_q)
					PH_FIRST, PH_OPC_LIT, PH_OPC_AFTER_LIT, PH_OPC_AFTER_TRAIL: begin
						if (phase_q == PH_FIRST && in_byte > 8'd17) begin
							if (in_byte - 8'd17 < 8'd4) begin
								trail_n = 2'(in_byte - 8'd17);
								ph_n = PH_TRAILS;
							end else begin
								rem_n = LW'(in_byte - 8'd17);
								ph_n = PH_LITERALS;
							end
						end else begin
							held_n = in_byte;
							if (in_byte >= 8'd64) begin
								ph_n = PH_SHORT_B;
							end else if (in_byte >= 8'd32) begin
								rem_n = LW'(in_byte[4:0]);
								ph_n = (in_byte[4:0] == 5'd0) ? PH_M34_EXT : PH_M34_D0;
							end else if (in_byte >= 8'd16) begin
								rem_n = LW'(in_byte[2:0]);
								ph_n = (in_byte[2:0] == 3'd0) ? PH_M34_EXT : PH_M34_D0;
							end else if (phase_q == PH_OPC_AFTER_LIT) begin
								ph_n = PH_SHORT_A;
							end else if (phase_q == PH_OPC_AFTER_TRAIL) begin
								ph_n = PH_SHORT_B;
							end else if (in_byte == 8'd0) begin
								rem_n = '0;
								ph_n = PH_LIT_EXT;
							end else begin
								rem_n = LW'(in_byte) + LW'(3);
								ph_n = PH_LITERALS;
							end
						end
					end
					PH_LIT_EXT, PH_M34_EXT: begin
						if (in_byte == 8'd0) add = (LW+1)'(255);
						else if (phase_q == PH_LIT_EXT) add = (LW+1)'(in_byte) + (LW+1)'(18);
						else if (held_q >= 8'd32) add = (LW+1)'(in_byte) + (LW+1)'(31);
						else add = (LW+1)'(in_byte) + (LW+1)'(7);
						len = {1'b0, rem_q} + add;
						if (len > LEN_MAX) begin
							err = ERR_OVERFLOW;
						end else begin
							rem_n = len[LW-1:0];
							if (in_byte != 8'd0)
								ph_n = (phase_q == PH_LIT_EXT) ? PH_LITERALS : PH_M34_D0;
						end
					end
					PH_LITERALS: begin
						v = 1'b1;
						wr = 1'b1;
						if (rem_q != '0) rem_n = rem_q - 1'b1;
						if (rem_n == '0) ph_n = PH_OPC_AFTER_LIT;
					end
					PH_TRAILS: begin
						v = 1'b1;
						wr = 1'b1;
						if (trail_q != 2'd0) trail_n = trail_q - 1'b1;
						if (trail_n == 2'd0) ph_n = PH_OPC_AFTER_TRAIL;
					end
					PH_SHORT_A: begin
						do_match = 1'b1;
						d = CW'(16'h0801) + CW'(held_q[7:2]) + CW'({in_byte, 2'b00});
						len = (LW+1)'(3);
					end
					PH_SHORT_B: begin
						do_match = 1'b1;
						if (held_q >= 8'd64) begin
							d = CW'(1) + CW'(held_q[4:2]) + CW'({in_byte, 3'b000});
							len = (LW+1)'(held_q[7:5]) + (LW+1)'(1);
						end else begin
							d = CW'(1) + CW'(held_q[7:2]) + CW'({in_byte, 2'b00});
							len = (LW+1)'(2);
						end
					end
					PH_M34_D0: begin
						dist0_n = in_byte;
						trail_n = in_byte[1:0];
						ph_n = PH_M34_D1;
					end
					PH_M34_D1: begin
						off = {2'b00, in_byte, dist0_q[7:2]};
						len = {1'b0, rem_q} + (LW+1)'(2);
						if (held_q >= 8'd32) begin
							do_match = 1'b1;
							d = CW'(off) + CW'(1);
						end else if (held_q[3] == 1'b0 && off == 16'd0) begin
							if (len > LEN_MAX) err = ERR_OVERFLOW;
							else begin
								rem_n = '0;
								ph_n = PH_DONE;
							end
						end else begin
							do_match = 1'b1;
							d = CW'({held_q[3], 14'd0}) + CW'(off) + CW'(17'h4000);
						end
					end
					default: ;
				endcase
				if (do_match) begin
					if (d == '0 || d > written_q) err = ERR_DIST;
					else if (len > LEN_MAX) err = ERR_OVERFLOW;
					else begin
						rem_n = len[LW-1:0];
						ph_n = PH_COPY;
						if (phase_q != PH_M34_D1) trail_n = held_q[1:0];
						srcw = ({1'b0, CW'(wpos_q)} >= {1'b0, d}) ?
							{1'b0, CW'(wpos_q)} - {1'b0, d} :
							{1'b0, CW'(wpos_q)} + (CW+1)'(HISTORY_DEPTH) - {1'b0, d};
						src_n = srcw[AW-1:0];
					end
				end
				if (err == ERR_OK && in_last && ph_n != PH_DONE) err = ERR_BAD_END;
			end
			if (err != ERR_OK && phase_q != PH_HALT && phase_q != PH_DONE
				&& phase_q != PH_COPY) begin
				ph_n = PH_HALT;
				held_n = {5'd0, err};
				rem_n = '0;
			end
			if (wr) begin
				wpos_n = nxt(wpos_q);
				if (written_q < CW'(HISTORY_DEPTH)) written_n = written_q + 1'b1;
			end
		end
		ob = v ? in_byte : 8'd0;
	end

	// A copy byte is read from memory in the result stage; a read of the entry
	// being written in the same cycle takes the forwarded byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST; wpos_q <= '0; src_q <= '0; written_q <= '0;
			rem_q <= '0; dist0_q <= '0; held_q <= '0; trail_q <= '0;
			full_s1 <= 1'b0; rd_s1 <= 1'b0; fwd_s1 <= 1'b0;
			wr_q <= 1'b0; waddr_q <= '0;
		end else begin
			wr_q <= take && wr;
			if (full_s1 && !out_stall && !take) full_s1 <= 1'b0;
			if (take) begin
				phase_q <= ph_n; wpos_q <= wpos_n; src_q <= src_n;
				written_q <= written_n; rem_q <= rem_n; dist0_q <= dist0_n;
				held_q <= held_n; trail_q <= trail_n;
				full_s1 <= 1'b1;
				rd_s1 <= is_copy;
				fwd_s1 <= is_copy && wr_q && (waddr_q == src_q);
				waddr_q <= wpos_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rvalid_s1 <= v;
			rbyte_s1 <= ob;
			rbusy_s1 <= (ph_n == PH_COPY);
			rdone_s1 <= (ph_n == PH_DONE);
			rerr_s1 <= err;
			fwd_byte_q <= out_byte;
		end
	end

	assign res_valid = full_s1;
	assign out_valid = rvalid_s1;
	assign out_byte = rd_s1 ? (fwd_s1 ? fwd_byte_q : hrdata) : rbyte_s1;
	assign busy_res = rbusy_s1;
	assign done_res = rdone_s1;
	assign error_code = rerr_s1;

`ifndef SYNTHESIS
	a_halt_stays: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT) else $error("halt left");
	a_rem_copy: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COPY |-> rem_q != '0) else $error("empty copy");
	a_written: assert property (@(posedge clk) disable iff (!arst_n)
		written_q <= CW'(HISTORY_DEPTH)) else $error("count overrun");
`endif

endmodule

// File: hw/rtl/lzo_history.sv
// History memory: one write port, one read port with registered data.
module lzo_history #(
	parameter int DEPTH = 65536,
	parameter int AW = 16
) (
	input  logic                clk,
	input  lzo_pkg::hist_ctl_t  ctl,
	input  logic [AW-1:0]       waddr,
	input  logic [AW-1:0]       raddr,
	output logic [7:0]          rdata
);
	import lzo_pkg::*;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
